// ===== hdl/dlrs_pkg.sv =====
`timescale 1ns / 1ps

package dlrs_pkg;

    localparam int HOLD_DEPTH  = 16;
    localparam int MAX_FIELDS  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
    localparam int Q_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int FCNT_W     = 7;
    localparam int FNUM_W     = 6;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [FCNT_W-1:0] LIMIT_RESET = 7'd64;

    // configuration register indexes
    localparam logic CFG_DELIMITER   = 1'b0;
    localparam logic CFG_FIELD_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        M_START,
        M_PLAIN,
        M_QUOTED,
        M_QSEEN,
        M_IGNORE
    } t_mode;

    typedef enum logic {
        PH_RUN,
        PH_FINAL
    } t_phase;

    // queued input byte plus front-end classification
    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_end;
        logic       white;
    } t_item;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              field_done;
        logic [FNUM_W-1:0] field_number;
        logic              too_many_fields;
        logic              hold_overflow;
        logic              row_done;
    } t_result;

    typedef struct packed {
        logic              emit;
        t_mode             mode;
        logic [FCNT_W-1:0] cnt;
        logic              fields_ovf;
        t_result           res;
    } t_parse;

    function automatic logic is_white(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

// ===== hdl/dlrs_if.sv =====
`timescale 1ns / 1ps

interface dlrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       row_end;

    modport source (output valid, output data_byte, output row_end, input ready);
    modport sink   (input valid, input data_byte, input row_end, output ready);
endinterface

interface dlrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_done;
    logic [5:0] field_number;
    logic       too_many_fields;
    logic       hold_overflow;
    logic       row_done;

    modport source (
        output valid, output out_byte, output byte_valid, output field_done,
        output field_number, output too_many_fields, output hold_overflow,
        output row_done, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input field_done,
        input field_number, input too_many_fields, input hold_overflow,
        input row_done, output ready
    );
endinterface

// ===== hdl/dlrs_front.sv =====
`timescale 1ns / 1ps

module dlrs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dlrs_in_if.sink         i_in,
    input  logic            i_pop,
    output logic            o_head_valid,
    output dlrs_pkg::t_item o_head
);

    dlrs_pkg::t_item                    r_q [dlrs_pkg::QUEUE_DEPTH];
    logic [dlrs_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [dlrs_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [dlrs_pkg::Q_CNT_W-1:0]       r_count;
    logic                               push;
    logic                               pop;
    dlrs_pkg::t_item                    item;

    assign i_in.ready   = (r_count != dlrs_pkg::Q_CNT_W'(dlrs_pkg::QUEUE_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        item.data_byte = i_in.data_byte;
        item.row_end   = i_in.row_end;
        item.white     = dlrs_pkg::is_white(i_in.data_byte);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == dlrs_pkg::Q_PTR_W'(dlrs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == dlrs_pkg::Q_PTR_W'(dlrs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/dlrs_back.sv =====
`timescale 1ns / 1ps

module dlrs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_delimiter,
    input  logic [dlrs_pkg::FCNT_W-1:0] i_field_limit,
    input  logic                        i_head_valid,
    input  dlrs_pkg::t_item             i_head,
    output logic                        o_pop,
    dlrs_out_if.source                  o_out
);

    dlrs_pkg::t_phase                   r_phase, n_phase;
    dlrs_pkg::t_mode                    r_mode, n_mode;
    logic [dlrs_pkg::FCNT_W-1:0]        r_cnt, n_cnt;
    logic                               r_fovf, n_fovf;
    logic                               r_hovf, n_hovf;
    logic [dlrs_pkg::HOLD_CNT_W-1:0]    r_held_cnt, n_held_cnt;
    logic [dlrs_pkg::HOLD_CNT_W-1:0]    r_idx, n_idx;
    logic [7:0]                         r_held [dlrs_pkg::HOLD_DEPTH];
    logic                               r_out_valid;
    dlrs_pkg::t_result                  r_out;

    logic                               slot_ok;
    logic                               load;
    logic                               hold_wr;
    logic                               replay;
    logic                               open_field;
    logic [7:0]                         src_byte;
    logic [dlrs_pkg::FCNT_W-1:0]        limit;
    dlrs_pkg::t_parse                   p;
    dlrs_pkg::t_result                  res;

    function automatic dlrs_pkg::t_parse parse_byte(
        input dlrs_pkg::t_mode             mode,
        input logic [dlrs_pkg::FCNT_W-1:0] cnt,
        input logic                        fovf,
        input logic                        hovf,
        input logic [7:0]                  b,
        input logic                        is_d,
        input logic [dlrs_pkg::FCNT_W-1:0] lim
    );
        dlrs_pkg::t_parse q;
        logic             is_q;
        q            = '0;
        q.mode       = mode;
        q.cnt        = cnt;
        q.fields_ovf = fovf;
        is_q         = (b == dlrs_pkg::QUOTE_BYTE);
        unique case (mode)
            dlrs_pkg::M_START: begin
                if (cnt >= lim) begin
                    q.fields_ovf = 1'b1;
                    q.mode       = dlrs_pkg::M_IGNORE;
                end else if (is_q) begin
                    q.mode = dlrs_pkg::M_QUOTED;
                end else if (is_d) begin
                    q.emit           = 1'b1;
                    q.res.field_done = 1'b1;
                    q.cnt            = cnt + 1'b1;
                end else begin
                    q.emit           = 1'b1;
                    q.res.byte_valid = 1'b1;
                    q.res.out_byte   = b;
                    q.mode           = dlrs_pkg::M_PLAIN;
                end
            end
            dlrs_pkg::M_PLAIN: begin
                q.emit = 1'b1;
                if (is_d) begin
                    q.res.field_done = 1'b1;
                    q.cnt            = cnt + 1'b1;
                    q.mode           = dlrs_pkg::M_START;
                end else begin
                    q.res.byte_valid = 1'b1;
                    q.res.out_byte   = b;
                end
            end
            dlrs_pkg::M_QUOTED: begin
                if (is_q) begin
                    q.mode = dlrs_pkg::M_QSEEN;
                end else begin
                    q.emit           = 1'b1;
                    q.res.byte_valid = 1'b1;
                    q.res.out_byte   = b;
                end
            end
            dlrs_pkg::M_QSEEN: begin
                q.emit = 1'b1;
                if (is_q) begin
                    // doubled quote inside a quoted field
                    q.res.byte_valid = 1'b1;
                    q.res.out_byte   = b;
                    q.mode           = dlrs_pkg::M_QUOTED;
                end else begin
                    // closing quote: this byte is swallowed
                    q.res.field_done = 1'b1;
                    q.cnt            = cnt + 1'b1;
                    q.mode           = dlrs_pkg::M_START;
                end
            end
            default: ;
        endcase
        q.res.field_number    = (q.res.byte_valid || q.res.field_done)
                                ? cnt[dlrs_pkg::FNUM_W-1:0] : '0;
        q.res.too_many_fields = q.fields_ovf;
        q.res.hold_overflow   = hovf;
        return q;
    endfunction

    assign limit   = (i_field_limit < dlrs_pkg::FCNT_W'(dlrs_pkg::MAX_FIELDS))
                     ? i_field_limit : dlrs_pkg::FCNT_W'(dlrs_pkg::MAX_FIELDS);
    assign slot_ok = !r_out_valid || o_out.ready;
    assign replay  = (r_idx < r_held_cnt);
    assign src_byte = replay ? r_held[r_idx[dlrs_pkg::HOLD_IDX_W-1:0]] : i_head.data_byte;
    assign open_field = (r_mode == dlrs_pkg::M_PLAIN) || (r_mode == dlrs_pkg::M_QUOTED) ||
                        (r_mode == dlrs_pkg::M_QSEEN);

    always_comb begin
        p = parse_byte(r_mode, r_cnt, r_fovf, r_hovf, src_byte,
                       (src_byte == i_delimiter), limit);
    end

    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        n_fovf     = r_fovf;
        n_hovf     = r_hovf;
        n_held_cnt = r_held_cnt;
        n_idx      = r_idx;
        o_pop      = 1'b0;
        load       = 1'b0;
        hold_wr    = 1'b0;
        res        = p.res;
        unique case (r_phase)
            dlrs_pkg::PH_RUN: begin
                if (i_head_valid) begin
                    if (r_mode == dlrs_pkg::M_IGNORE) begin
                        n_held_cnt = '0;
                        if (i_head.row_end) n_phase = dlrs_pkg::PH_FINAL;
                        else                o_pop   = 1'b1;
                    end else if (i_head.white) begin
                        if (i_head.row_end) begin
                            n_phase = dlrs_pkg::PH_FINAL;
                        end else begin
                            o_pop = 1'b1;
                            if (r_held_cnt < dlrs_pkg::HOLD_CNT_W'(dlrs_pkg::HOLD_DEPTH)) begin
                                hold_wr    = 1'b1;
                                n_held_cnt = r_held_cnt + 1'b1;
                            end else begin
                                n_hovf = 1'b1;
                            end
                        end
                    end else if (!p.emit || slot_ok) begin
                        // replay held whitespace one per cycle while the output is not stalled, then the byte itself
                        n_mode = p.mode;
                        n_cnt  = p.cnt;
                        n_fovf = p.fields_ovf;
                        load   = p.emit;
                        if (replay) begin
                            n_idx = r_idx + 1'b1;
                        end else begin
                            n_idx      = '0;
                            n_held_cnt = '0;
                            if (i_head.row_end) n_phase = dlrs_pkg::PH_FINAL;
                            else                o_pop   = 1'b1;
                        end
                    end
                end
            end
            dlrs_pkg::PH_FINAL: begin
                res                 = '0;
                res.field_done      = open_field;
                res.field_number    = open_field ? r_cnt[dlrs_pkg::FNUM_W-1:0] : '0;
                res.too_many_fields = r_fovf;
                res.hold_overflow   = r_hovf;
                res.row_done        = 1'b1;
                if (slot_ok) begin
                    load       = 1'b1;
                    o_pop      = 1'b1;
                    n_phase    = dlrs_pkg::PH_RUN;
                    n_mode     = dlrs_pkg::M_START;
                    n_cnt      = '0;
                    n_fovf     = 1'b0;
                    n_hovf     = 1'b0;
                    n_held_cnt = '0;
                    n_idx      = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hold_wr) begin
            r_held[r_held_cnt[dlrs_pkg::HOLD_IDX_W-1:0]] <= i_head.data_byte;
        end
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dlrs_pkg::PH_RUN;
            r_mode      <= dlrs_pkg::M_START;
            r_cnt       <= '0;
            r_fovf      <= 1'b0;
            r_hovf      <= 1'b0;
            r_held_cnt  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_cnt      <= n_cnt;
            r_fovf     <= n_fovf;
            r_hovf     <= n_hovf;
            r_held_cnt <= n_held_cnt;
            r_idx      <= n_idx;
            if (load)             r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out.out_byte;
    assign o_out.byte_valid      = r_out.byte_valid;
    assign o_out.field_done      = r_out.field_done;
    assign o_out.field_number    = r_out.field_number;
    assign o_out.too_many_fields = r_out.too_many_fields;
    assign o_out.hold_overflow   = r_out.hold_overflow;
    assign o_out.row_done        = r_out.row_done;

endmodule

// ===== hdl/delimited_row_field_splitter.sv =====
// Path: an accepted byte is written into the input queue, then parsed from the queue head
//   into the result register when nothing is held and the output is free.
// Sequencing: the parser handles one input byte per step, replays each held whitespace
//   byte as its own step and gives the row_done result its own step; a stalled output holds it.
// Reset (synchronous, active low) empties the input queue and the result register,
//   returns row state to field start and loads delimiter 44 and field limit 64.
`timescale 1ns / 1ps

module delimited_row_field_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dlrs_in_if.sink    i_in,
    dlrs_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]                  r_delimiter;
    logic [dlrs_pkg::FCNT_W-1:0] r_field_limit;
    logic                        head_valid;
    logic                        pop;
    dlrs_pkg::t_item             head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter   <= dlrs_pkg::DELIM_RESET;
            r_field_limit <= dlrs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dlrs_pkg::CFG_DELIMITER:   r_delimiter   <= i_cfg_data;
                dlrs_pkg::CFG_FIELD_LIMIT: r_field_limit <= i_cfg_data[dlrs_pkg::FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    dlrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    dlrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_delimiter   (r_delimiter),
        .i_field_limit (r_field_limit),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

// ===== hdl/dlrs_checker.sv =====
`timescale 1ns / 1ps

module dlrs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_field_done,
    input logic [5:0] i_field_number,
    input logic       i_row_done
);

    // a stalled transaction keeps its byte, byte_valid, field_done and row_done
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_byte_valid) && $stable(i_field_done) && $stable(i_row_done))
        else $error("result changed while stalled");

    // content bytes never carry an end marker
    a_byte_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_valid |-> !i_field_done && !i_row_done)
        else $error("content byte with end marker");

    // row end without content reports field 0 and a zero byte
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid && !i_field_done |->
        (i_field_number == 6'd0) && (i_out_byte == 8'd0))
        else $error("stale field number or byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind delimited_row_field_splitter dlrs_checker u_dlrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_byte_valid   (o_out.byte_valid),
    .i_field_done   (o_out.field_done),
    .i_field_number (o_out.field_number),
    .i_row_done     (o_out.row_done)
);
